// ===== rtl/sha1md_pkg.sv =====
`default_nettype none

package sha1md_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 64;
  localparam int unsigned BLOCK_WORDS         = 16;
  localparam int unsigned ROUND_COUNT         = 80;
  localparam int unsigned ROUNDS_PER_STAGE    = ROUND_COUNT / 4;

  localparam logic [31:0] INIT_H [5] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5a82_7999, 32'h6ed9_eba1, 32'h8f1b_bcdc, 32'hca62_c1d6
  };

  // padding marker when it opens a fresh word
  localparam logic [31:0] PAD_MARKER_WORD = 32'h8000_0000;
  localparam logic [7:0]  PAD_MARKER_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_h0;
    logic [31:0] digest_h1;
    logic [31:0] digest_h2;
    logic [31:0] digest_h3;
    logic [31:0] digest_h4;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_UPDATE,
    ST_DIGEST
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/sha1_message_digest.sv =====
// SHA-1 digest engine, one 32-bit big-endian message word per transaction.
//
// Input channel (item_valid / item_stall / item): data_word carries message
// bytes, first byte in bits 31..24. byte_count gives the valid bytes (0 to 4,
// values above 4 count as 4); it only matters on the transaction with last set.
// item_stall is high whenever the engine is busy: it takes one word at a time.
// The 16th word of a block starts compression: 80 rounds on the single round
// unit, then the chaining update, with item_stall high throughout.
// Last word: padding words are pushed one per cycle, then one or two blocks
// are compressed, depending on how full the block was, before digest_valid rises.
// Output channel (digest_valid / digest_stall / digest): one transaction per
// message, holding h0..h4. The digest sits in its own register; the engine
// keeps taking words of the next message while it waits, and only holds off
// writing the next digest until the previous one has been taken.
// Reset (rst, synchronous) loads the standard initial chaining words and
// clears the fill count, bit length and output valid.
`default_nettype none

module sha1_message_digest #(
  parameter int unsigned LENGTH_BITS = sha1md_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  sha1md_pkg::msg_word_t item,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output sha1md_pkg::digest_t  digest
);
  import sha1md_pkg::*;

  state_t state, state_next;

  // chaining words and working variables
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;

  // block buffer as a shift line: wbuf[0] is the oldest word / current round word
  logic [31:0] wbuf [BLOCK_WORDS];
  logic [3:0]  fill;
  logic [6:0]  round_idx;
  logic [LENGTH_BITS-1:0] msg_len;
  logic        padding;   // message ended, padding in progress
  logic        len_sent;  // upper length word already pushed
  logic        pend;      // full 0x80 marker word still to push

  // control from the sequencer
  logic        accept;
  logic        push_en;
  logic [31:0] push_word;
  logic        digest_load;

  logic [2:0]  count_sat;
  logic [31:0] last_word;
  logic [LENGTH_BITS-1:0] len_add;
  logic [63:0] len64;

  // round unit
  logic [31:0] f, k, t, w_new;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  assign count_sat = (item.byte_count > 3'd4) ? 3'd4 : item.byte_count;
  assign len_add   = item.last ? LENGTH_BITS'({count_sat, 3'b000})
                               : LENGTH_BITS'(6'd32);
  assign len64     = 64'(msg_len);

  // last word: keep the valid bytes and place the marker right after them
  always_comb begin
    case (count_sat)
      3'd0:    last_word = PAD_MARKER_WORD;
      3'd1:    last_word = {item.data_word[31:24], PAD_MARKER_BYTE, 16'h0000};
      3'd2:    last_word = {item.data_word[31:16], PAD_MARKER_BYTE, 8'h00};
      3'd3:    last_word = {item.data_word[31:8], PAD_MARKER_BYTE};
      default: last_word = item.data_word;
    endcase
  end

  // sequencer
  always_comb begin
    state_next  = state;
    push_en     = 1'b0;
    push_word   = '0;
    digest_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          push_en   = 1'b1;
          push_word = item.last ? last_word : item.data_word;
          if (fill == 4'd15) begin
            state_next = ST_ROUNDS;
          end else if (item.last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pend) begin
          push_word = PAD_MARKER_WORD;
        end else if (fill == 4'd14) begin
          push_word = len64[63:32];
        end else if (fill == 4'd15 && len_sent) begin
          push_word = len64[31:0];
        end
        if (fill == 4'd15) begin
          state_next = ST_ROUNDS;
        end
      end
      ST_ROUNDS: begin
        if (round_idx == 7'(ROUND_COUNT - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (len_sent) begin
          state_next = ST_DIGEST;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_DIGEST: begin
        if (!digest_valid || !digest_stall) begin
          digest_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // round function and constant by stage
  always_comb begin
    if (round_idx < 7'(ROUNDS_PER_STAGE)) begin
      f = (b & c) | (~b & d);
      k = ROUND_K[0];
    end else if (round_idx < 7'(2 * ROUNDS_PER_STAGE)) begin
      f = b ^ c ^ d;
      k = ROUND_K[1];
    end else if (round_idx < 7'(3 * ROUNDS_PER_STAGE)) begin
      f = (b & c) | (b & d) | (c & d);
      k = ROUND_K[2];
    end else begin
      f = b ^ c ^ d;
      k = ROUND_K[3];
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + wbuf[0] + k;

  // schedule: w[t+16] from w[t+13], w[t+8], w[t+2], w[t]
  logic [31:0] w_mix;
  assign w_mix = wbuf[13] ^ wbuf[8] ^ wbuf[2] ^ wbuf[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= INIT_H[i];
      end
      fill         <= '0;
      round_idx    <= '0;
      msg_len      <= '0;
      padding      <= 1'b0;
      len_sent     <= 1'b0;
      pend         <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      if (push_en) begin
        fill <= fill + 4'd1;
      end
      if (push_en && fill == 4'd15) begin
        round_idx <= '0;
      end else if (state == ST_ROUNDS) begin
        round_idx <= round_idx + 7'd1;
      end
      if (accept) begin
        msg_len <= msg_len + len_add;
        if (item.last) begin
          padding <= 1'b1;
          pend    <= (count_sat == 3'd4);
        end
      end
      if (state == ST_PAD) begin
        if (pend) begin
          pend <= 1'b0;
        end else if (fill == 4'd14) begin
          len_sent <= 1'b1;
        end
      end
      if (state == ST_UPDATE) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (digest_load) begin
        for (int i = 0; i < 5; i++) begin
          h[i] <= INIT_H[i];
        end
        msg_len  <= '0;
        padding  <= 1'b0;
        len_sent <= 1'b0;
      end
      if (digest_load) begin
        digest_valid <= 1'b1;
      end else if (!digest_stall) begin
        digest_valid <= 1'b0;
      end
    end
  end

  // payload: buffer, working variables, digest register
  always_ff @(posedge clk) begin
    if (push_en || state == ST_ROUNDS) begin
      for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
        wbuf[j] <= wbuf[j+1];
      end
      wbuf[BLOCK_WORDS-1] <= push_en ? push_word : w_new;
    end
    if (push_en && fill == 4'd15) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (state == ST_ROUNDS) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
    if (digest_load) begin
      digest.digest_h0 <= h[0];
      digest.digest_h1 <= h[1];
      digest.digest_h2 <= h[2];
      digest.digest_h3 <= h[3];
      digest.digest_h4 <= h[4];
    end
  end

`ifndef SYNTHESIS
  // a block always starts compressing from an empty buffer count
  a_rounds_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUNDS |-> fill == 4'd0)
    else $error("fill count not wrapped during compression");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUNDS |-> round_idx < 7'(ROUND_COUNT))
    else $error("round counter out of range");

  a_digest_src: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> $past(state) == ST_DIGEST)
    else $error("digest raised outside the digest state");

  a_len_in_pad: assert property (@(posedge clk) disable iff (rst)
    len_sent |-> padding && !pend)
    else $error("length pushed outside padding");
`endif

endmodule

`default_nettype wire
